@@ rtl/htpd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htpd_pkg
// Types and constants shared by the single-wire pulse decoder modules.
// ----------------------------------------------------------------------------
package htpd_pkg;

	localparam int HIST_LEN   = 80;
	localparam int DATA_BITS  = 40;
	localparam int COUNT_W    = 7;

	localparam logic [COUNT_W-1:0] COUNT_FULL = 7'd80;

	localparam logic [14:0] DHT22_NEG_MAX = 15'd400;
	localparam logic [14:0] DHT22_POS_MAX = 15'd800;
	localparam logic [15:0] DHT22_HUM_MAX = 16'd1000;
	localparam logic [7:0]  DHT11_TEMP_MAX = 8'd80;
	localparam logic [7:0]  DHT11_HUM_MAX  = 8'd100;

	localparam logic KIND_DHT22 = 1'b0;
	localparam logic KIND_DHT11 = 1'b1;

	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_KIND      = 1'b1;

	localparam logic [15:0] THRESHOLD_RESET = 16'd53;

	typedef struct packed {
		logic [15:0] bit_threshold_ticks;
		logic        sensor_kind;
	} cfg_t;

	typedef struct packed {
		logic [DATA_BITS-1:0] data_bits;
		logic                 full_frame;
	} frame_t;

endpackage
`default_nettype wire

@@ rtl/htpd_sample_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htpd_sample_if
// Request channel for measured line intervals.
// ----------------------------------------------------------------------------
interface htpd_sample_if;
	logic        valid;
	logic        ready;
	logic [15:0] interval_ticks;
	logic        frame_end;

	modport source (output valid, output interval_ticks, output frame_end, input ready);
	modport sink (input valid, input interval_ticks, input frame_end, output ready);
endinterface
`default_nettype wire

@@ rtl/htpd_reading_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htpd_reading_if
// Result channel for decoded sensor readings.
// ----------------------------------------------------------------------------
interface htpd_reading_if;
	logic              valid;
	logic              ready;
	logic signed [10:0] temperature_tenths;
	logic [9:0]        humidity_tenths;
	logic              reading_valid;

	modport source (output valid, output temperature_tenths, output humidity_tenths,
		output reading_valid, input ready);
	modport sink (input valid, input temperature_tenths, input humidity_tenths,
		input reading_valid, output ready);
endinterface
`default_nettype wire

@@ rtl/humidity_temperature_pulse_decoder_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// humidity_temperature_pulse_decoder_top
// Single-wire humidity/temperature sensor frame decoder.
// ----------------------------------------------------------------------------
// Takes one interval request per clock cycle while the queue has room; each is
// compared with the threshold and shifted into an 80-bit history in the front
// stage. An interval marked frame end captures the frame into a short queue
// (QUEUE_DEPTH frames), and the back stage decodes it into the output register,
// so a reading passes through the queue entry and then the output register.
// Requests stall whenever the queue is full.
// ----------------------------------------------------------------------------
module humidity_temperature_pulse_decoder_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	htpd_sample_if.sink      samples,
	htpd_reading_if.source   readings
);

	htpd_pkg::cfg_t   cfg_q;
	htpd_pkg::frame_t push_data;
	htpd_pkg::frame_t pop_data;
	logic             push_valid;
	logic             push_ready;
	logic             pop_valid;
	logic             pop;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_threshold_ticks <= htpd_pkg::THRESHOLD_RESET;
			cfg_q.sensor_kind         <= htpd_pkg::KIND_DHT22;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				htpd_pkg::REG_THRESHOLD: cfg_q.bit_threshold_ticks <= pwdata[15:0];
				htpd_pkg::REG_KIND:      cfg_q.sensor_kind <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			htpd_pkg::REG_THRESHOLD: prdata = {16'h0000, cfg_q.bit_threshold_ticks};
			htpd_pkg::REG_KIND:      prdata = {31'h0, cfg_q.sensor_kind};
			default:                 prdata = '0;
		endcase
	end

	htpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.threshold  (cfg_q.bit_threshold_ticks),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	htpd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop        (pop)
	);

	htpd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.sensor_kind (cfg_q.sensor_kind),
		.pop_valid   (pop_valid),
		.pop_data    (pop_data),
		.pop         (pop),
		.readings    (readings)
	);

endmodule
`default_nettype wire

@@ rtl/htpd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htpd_front
// Slices each interval into a bit decision, keeps the 80-deep history and
// hands a captured frame to the queue at frame end.
// ----------------------------------------------------------------------------
module htpd_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	htpd_sample_if.sink          samples,
	input  wire logic [15:0]     threshold,
	input  wire logic            push_ready,
	output logic                 push_valid,
	output htpd_pkg::frame_t     push_data
);

	logic [htpd_pkg::HIST_LEN-1:0] history_q;
	logic [htpd_pkg::HIST_LEN-1:0] history_next;
	logic [htpd_pkg::COUNT_W-1:0]  count_q;
	logic [htpd_pkg::COUNT_W-1:0]  count_next;
	logic                          decision;
	logic                          accept;

	assign samples.ready = push_ready;
	assign accept        = samples.valid && push_ready;
	assign decision      = samples.interval_ticks >= threshold;
	assign history_next  = {history_q[htpd_pkg::HIST_LEN-2:0], decision};
	assign count_next    = (count_q < htpd_pkg::COUNT_FULL) ? count_q + 7'd1 : count_q;

	always_comb begin
		for (int j = 0; j < htpd_pkg::DATA_BITS; j++) begin
			push_data.data_bits[j] = history_next[2*j+1];
		end
		push_data.full_frame = count_next == htpd_pkg::COUNT_FULL;
	end

	assign push_valid = accept && samples.frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			history_q <= '0;
			count_q   <= '0;
		end else if (accept) begin
			if (samples.frame_end) begin
				history_q <= '0;
				count_q   <= '0;
			end else begin
				history_q <= history_next;
				count_q   <= count_next;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/htpd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htpd_queue
// Short FIFO of captured frames between front and back.
// ----------------------------------------------------------------------------
module htpd_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	input  wire htpd_pkg::frame_t push_data,
	output logic                  push_ready,
	output logic                  pop_valid,
	output htpd_pkg::frame_t      pop_data,
	input  wire logic             pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	htpd_pkg::frame_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = fill_q != CW'(DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/htpd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htpd_back
// Checks the checksum, decodes and range-checks a frame and holds the
// reading in the output register.
// ----------------------------------------------------------------------------
module htpd_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             sensor_kind,
	input  wire logic             pop_valid,
	input  wire htpd_pkg::frame_t pop_data,
	output logic                  pop,
	htpd_reading_if.source        readings
);

	logic [7:0]  b0, b1, b2, b3, b4;
	logic [9:0]  byte_sum;
	logic        sum_ok;
	logic [15:0] hum22;
	logic [14:0] mag22;
	logic        neg22;
	logic        t_ok;
	logic        h_ok;
	logic        good;
	logic [10:0] temp_dec;
	logic [9:0]  hum_dec;
	logic [11:0] hum11;
	logic [11:0] temp11;

	logic              out_valid_q;
	logic signed [10:0] temp_q;
	logic [9:0]        hum_q;
	logic              good_q;

	assign {b0, b1, b2, b3, b4} = pop_data.data_bits;
	assign byte_sum = {2'b00, b0} + {2'b00, b1} + {2'b00, b2} + {2'b00, b3};
	assign sum_ok   = byte_sum[7:0] == b4;
	assign hum22    = {b0, b1};
	assign neg22    = b2[7];
	assign mag22    = {b2[6:0], b3};
	assign hum11    = ({4'b0000, b0} << 3) + ({4'b0000, b0} << 1);
	assign temp11   = ({4'b0000, b2} << 3) + ({4'b0000, b2} << 1);

	always_comb begin
		case (sensor_kind)
			htpd_pkg::KIND_DHT22: begin
				t_ok     = neg22 ? (mag22 <= htpd_pkg::DHT22_NEG_MAX)
				                 : (mag22 <= htpd_pkg::DHT22_POS_MAX);
				h_ok     = hum22 <= htpd_pkg::DHT22_HUM_MAX;
				temp_dec = neg22 ? 11'(-mag22[10:0]) : mag22[10:0];
				hum_dec  = hum22[9:0];
			end
			htpd_pkg::KIND_DHT11: begin
				t_ok     = b2 <= htpd_pkg::DHT11_TEMP_MAX;
				h_ok     = b0 <= htpd_pkg::DHT11_HUM_MAX;
				temp_dec = temp11[10:0];
				hum_dec  = hum11[9:0];
			end
			default: begin
				t_ok     = 1'b0;
				h_ok     = 1'b0;
				temp_dec = '0;
				hum_dec  = '0;
			end
		endcase
	end

	assign good = pop_data.full_frame && sum_ok && t_ok && h_ok;
	assign pop  = pop_valid && (!out_valid_q || readings.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (readings.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			temp_q <= good ? $signed(temp_dec) : '0;
			hum_q  <= good ? hum_dec : '0;
			good_q <= good;
		end
	end

	assign readings.valid              = out_valid_q;
	assign readings.temperature_tenths = temp_q;
	assign readings.humidity_tenths    = hum_q;
	assign readings.reading_valid      = good_q;

endmodule
`default_nettype wire

@@ bench/tb_humidity_temperature_pulse_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_humidity_temperature_pulse_decoder_top
// Self-checking bench for the single-wire sensor frame decoder.
// ----------------------------------------------------------------------------
// Drives interval requests in random bursts and stalls the reading channel on
// a pattern of its own. A local decoder model tracks the decision history and
// the frame count, decodes each frame end into the expected reading, and a
// monitor compares every reading taken from the block in order. Directed
// frames cover range limits, both sensor formats, checksum faults, short and
// long frames and the threshold extremes; random frames in several register
// settings follow.
// ----------------------------------------------------------------------------
module tb_humidity_temperature_pulse_decoder_top;

	localparam int TEMP_MIN_TENTHS = -400;
	localparam int TEMP_MAX_TENTHS = 800;
	localparam int HUM_MAX_TENTHS  = 1000;
	localparam int RANDOM_ITEMS    = 40;
	localparam int RANDOM_PHASES   = 4;
	localparam int DRAIN_CYCLES    = 6;

	typedef struct packed {
		logic signed [10:0] temp;
		logic [9:0]         hum;
		logic               ok;
	} reading_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	htpd_sample_if  samples_if();
	htpd_reading_if readings_if();

	humidity_temperature_pulse_decoder_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.samples  (samples_if),
		.readings (readings_if)
	);

	logic [htpd_pkg::HIST_LEN-1:0] decision_bits;
	logic [htpd_pkg::COUNT_W-1:0]  frame_count;
	logic [15:0]                   threshold_q;
	logic                          kind_q;
	reading_t                      expected_readings[$];
	int                            error_count;
	int                            sent_items;
	int                            send_burst_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL humidity_temperature_pulse_decoder_top");
		$finish;
	end

	// decode one accepted interval into the expected reading, if any
	task automatic predict_interval(input logic [15:0] ticks, input logic last);
		logic [39:0] word;
		logic [7:0]  sum;
		logic        ok;
		int          temp;
		int          hum;
		int          mag;
		reading_t    r;
		decision_bits = {decision_bits[htpd_pkg::HIST_LEN-2:0], ticks >= threshold_q};
		if (frame_count < htpd_pkg::COUNT_FULL)
			frame_count++;
		if (!last)
			return;
		for (int k = 0; k < htpd_pkg::DATA_BITS; k++)
			word[htpd_pkg::DATA_BITS-1-k] = decision_bits[htpd_pkg::HIST_LEN-1-2*k];
		sum = word[39:32] + word[31:24] + word[23:16] + word[15:8];
		ok = (frame_count >= htpd_pkg::COUNT_FULL) && (sum == word[7:0]);
		temp = 0;
		hum = 0;
		if (ok) begin
			if (kind_q == htpd_pkg::KIND_DHT22) begin
				hum = int'(word[39:24]);
				mag = int'(word[22:8]);
				temp = word[23] ? -mag : mag;
			end else begin
				hum = int'(word[39:32]) * 10;
				temp = int'(word[23:16]) * 10;
			end
			if (temp < TEMP_MIN_TENTHS || temp > TEMP_MAX_TENTHS || hum > HUM_MAX_TENTHS)
				ok = 1'b0;
		end
		if (!ok) begin
			temp = 0;
			hum = 0;
		end
		r.temp = 11'(temp);
		r.hum = 10'(hum);
		r.ok = ok;
		expected_readings.push_back(r);
		decision_bits = '0;
		frame_count = '0;
	endtask

	always @(posedge clk) begin : reading_check
		reading_t want;
		if (readings_if.valid === 1'b1 && readings_if.ready === 1'b1) begin
			if (expected_readings.size() == 0) begin
				$error("reading with none pending: temperature_tenths %0d",
					$signed(readings_if.temperature_tenths));
				error_count++;
			end else begin
				want = expected_readings.pop_front();
				if (readings_if.temperature_tenths !== want.temp) begin
					$error("temperature_tenths: expected %0d, got %0d", $signed(want.temp),
						$signed(readings_if.temperature_tenths));
					error_count++;
				end
				if (readings_if.humidity_tenths !== want.hum) begin
					$error("humidity_tenths: expected %0d, got %0d", want.hum,
						readings_if.humidity_tenths);
					error_count++;
				end
				if (readings_if.reading_valid !== want.ok) begin
					$error("reading_valid: expected %0b, got %0b", want.ok,
						readings_if.reading_valid);
					error_count++;
				end
			end
		end
	end

	initial begin : reading_stall
		int stall_mode;
		int stall_left;
		stall_mode = 0;
		stall_left = 0;
		readings_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left == 0) begin
				stall_mode = $urandom_range(3, 0);
				stall_left = $urandom_range(64, 8);
			end
			stall_left--;
			case (stall_mode)
				0: begin
					readings_if.ready <= 1'b1;
				end
				1: begin
					readings_if.ready <= 1'($urandom_range(1, 0));
				end
				2: begin
					readings_if.ready <= ($urandom_range(3, 0) == 0);
				end
				default: begin
					readings_if.ready <= (stall_left % 5 != 0);
				end
			endcase
		end
	end

	task automatic send_interval(input logic [15:0] ticks, input logic last);
		if (send_burst_left == 0) begin
			samples_if.valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
			send_burst_left = ($urandom_range(5, 0) == 0) ? $urandom_range(300, 100) :
				$urandom_range(24, 1);
		end
		samples_if.valid <= 1'b1;
		samples_if.interval_ticks <= ticks;
		samples_if.frame_end <= last;
		@(posedge clk);
		while (samples_if.ready !== 1'b1) @(posedge clk);
		send_burst_left--;
		sent_items++;
		predict_interval(ticks, last);
	endtask

	// hold requests until every pending reading has come out
	task automatic pause_until_drained();
		samples_if.valid <= 1'b0;
		send_burst_left = 0;
		@(posedge clk);
		while (expected_readings.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic reg_idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (reg_idx)
			htpd_pkg::REG_THRESHOLD: begin
				threshold_q = value[15:0];
			end
			default: begin
				kind_q = value[0];
			end
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] threshold, input logic kind);
		pause_until_drained();
		write_reg(htpd_pkg::REG_THRESHOLD, {16'($urandom), threshold});
		write_reg(htpd_pkg::REG_KIND, {31'($urandom), kind});
	endtask

	function automatic logic [15:0] bit_interval(input logic b, input bit tight);
		if (threshold_q == 16'd0)
			return 16'($urandom);
		if (b)
			return tight ? threshold_q : 16'($urandom_range(65535, threshold_q));
		return tight ? threshold_q - 16'd1 : 16'($urandom_range(threshold_q - 16'd1, 0));
	endfunction

	function automatic logic [39:0] with_checksum(input logic [31:0] data, input bit corrupt);
		logic [7:0] sum;
		sum = data[31:24] + data[23:16] + data[15:8] + data[7:0];
		if (corrupt)
			sum ^= 8'(1 << $urandom_range(7, 0));
		return {data, sum};
	endfunction

	// data bits on even positions, free intervals on odd ones, end on the last
	task automatic send_frame(input logic [39:0] word, input bit tight, input int lead);
		repeat (lead) send_interval(16'($urandom), 1'b0);
		for (int k = 0; k < htpd_pkg::DATA_BITS; k++) begin
			send_interval(bit_interval(word[htpd_pkg::DATA_BITS-1-k], tight), 1'b0);
			send_interval(16'($urandom), k == htpd_pkg::DATA_BITS - 1);
		end
	endtask

	function automatic logic [39:0] random_reading();
		logic [31:0] data;
		logic        neg;
		int          pick;
		pick = $urandom_range(9, 0);
		neg = 1'($urandom_range(1, 0));
		if (pick == 0)
			data = $urandom;
		else if (kind_q == htpd_pkg::KIND_DHT22)
			data = {16'($urandom_range(1000, 0)), neg, 15'($urandom_range(neg ? 400 : 800, 0))};
		else
			data = {8'($urandom_range(100, 0)), 8'($urandom), 8'($urandom_range(80, 0)),
				8'($urandom)};
		return with_checksum(data, pick == 1);
	endfunction

	task automatic send_random_frame();
		int pick;
		int n;
		pick = $urandom_range(99, 0);
		if (pick < 70) begin
			send_frame(random_reading(), $urandom_range(3, 0) == 0, 0);
		end else if (pick < 80) begin
			n = $urandom_range(79, 1);
			repeat (n - 1) send_interval(16'($urandom), 1'b0);
			send_interval(16'($urandom), 1'b1);
		end else if (pick < 90) begin
			send_frame(random_reading(), 1'b0, $urandom_range(30, 1));
		end else begin
			n = $urandom_range(10, 1);
			repeat (n) send_interval(16'($urandom), $urandom_range(9, 0) == 0);
		end
	endtask

	task automatic test_default_config();
		send_frame(with_checksum({16'd652, 1'b0, 15'd237}, 1'b0), 1'b1, 0);
		send_frame(with_checksum({16'd485, 1'b1, 15'd101}, 1'b0), 1'b0, 0);
	endtask

	task automatic test_dht22_limits();
		logic [31:0] cases[9];
		cases = '{
			{16'd0, 16'd0},
			{16'd1000, 1'b0, 15'd800},
			{16'd1000, 1'b1, 15'd400},
			{16'd0, 1'b1, 15'd0},
			{16'd500, 1'b0, 15'd801},
			{16'd500, 1'b1, 15'd401},
			{16'd1001, 16'd0},
			{16'hFFFF, 16'hFFFF},
			{16'd0, 1'b0, 15'h7FFF}
		};
		set_config(16'd200, htpd_pkg::KIND_DHT22);
		foreach (cases[i])
			send_frame(with_checksum(cases[i], 1'b0), 1'b0, 0);
	endtask

	task automatic test_frame_faults();
		send_frame(with_checksum({16'd420, 1'b0, 15'd215}, 1'b1), 1'b0, 0);
		send_interval(16'hFFFF, 1'b1);
		send_interval(16'h0000, 1'b1);
		repeat (78) send_interval(16'($urandom), 1'b0);
		send_interval(16'($urandom), 1'b1);
		send_frame(with_checksum({16'd733, 1'b1, 15'd55}, 1'b0), 1'b0, 20);
		send_frame(with_checksum({16'd10, 1'b0, 15'd10}, 1'b0), 1'b1, 0);
	endtask

	task automatic test_dht11_format();
		logic [31:0] cases[5];
		cases = '{
			{8'd100, 8'd7, 8'd80, 8'd9},
			{8'd0, 8'd0, 8'd0, 8'd0},
			{8'd101, 8'd0, 8'd20, 8'd0},
			{8'd50, 8'd0, 8'd81, 8'd0},
			{8'd255, 8'd255, 8'd255, 8'd255}
		};
		set_config(16'd1000, htpd_pkg::KIND_DHT11);
		foreach (cases[i])
			send_frame(with_checksum(cases[i], 1'b0), 1'b0, 0);
	endtask

	task automatic test_threshold_extremes();
		set_config(16'hFFFF, htpd_pkg::KIND_DHT22);
		send_frame(with_checksum({16'd999, 1'b1, 15'd399}, 1'b0), 1'b1, 0);
		set_config(16'd0, htpd_pkg::KIND_DHT22);
		send_frame(with_checksum({16'd300, 1'b0, 15'd300}, 1'b0), 1'b0, 0);
		set_config(16'd1, htpd_pkg::KIND_DHT11);
		send_frame(with_checksum({8'd45, 8'd0, 8'd23, 8'd0}, 1'b0), 1'b1, 0);
	endtask

	task automatic test_random_traffic();
		int phase_end;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase % 4)
				0: begin
					set_config(16'd1, htpd_pkg::KIND_DHT22);
				end
				1: begin
					set_config(16'hFFFF, htpd_pkg::KIND_DHT11);
				end
				default: begin
					set_config(16'($urandom_range(400, 2)), 1'($urandom_range(1, 0)));
				end
			endcase
			phase_end = sent_items + RANDOM_ITEMS / RANDOM_PHASES;
			while (sent_items < phase_end) begin
				send_random_frame();
				if ($urandom_range(39, 0) == 0)
					pause_until_drained();
			end
		end
	endtask

	initial begin
		error_count = 0;
		sent_items = 0;
		send_burst_left = 0;
		decision_bits = '0;
		frame_count = '0;
		threshold_q = htpd_pkg::THRESHOLD_RESET;
		kind_q = htpd_pkg::KIND_DHT22;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		samples_if.valid <= 1'b0;
		samples_if.interval_ticks <= '0;
		samples_if.frame_end <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_config();
		test_dht22_limits();
		test_frame_faults();
		test_dht11_format();
		test_threshold_extremes();
		test_random_traffic();
		pause_until_drained();
		if (error_count == 0)
			$display("PASS humidity_temperature_pulse_decoder_top");
		else
			$display("FAIL humidity_temperature_pulse_decoder_top");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/htpd_pkg.sv
rtl/htpd_sample_if.sv
rtl/htpd_reading_if.sv
rtl/htpd_front.sv
rtl/htpd_queue.sv
rtl/htpd_back.sv
rtl/humidity_temperature_pulse_decoder_top.sv
bench/tb_humidity_temperature_pulse_decoder_top.sv
